### design/slab_free_list_allocator_top_assert.svh
// Assertion macros for the allocator's port-level checker.
`ifndef SLAB_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define SLAB_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLFL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/slfl_pkg.sv
// Constants and codes of the slab free-list allocator.
package slfl_pkg;

  localparam int MAX_SLABS          = 16;
  localparam int INITIAL_SLABS      = 1;
  localparam int MAX_SLOTS_PER_SLAB = 128;

  localparam int LINK_DEPTH = MAX_SLABS * MAX_SLOTS_PER_SLAB;
  localparam int HANDLE_W   = 11;
  localparam int HEAD_W     = 12;
  localparam int COUNT_W    = 12;
  localparam int SLAB_W     = 5;
  localparam int SPP_W      = 8;
  localparam int TOTAL_W    = 32;

  localparam logic [HEAD_W-1:0]  LIST_EMPTY = HEAD_W'(LINK_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [SLAB_W-1:0]  SLAB_LIMIT = SLAB_W'(MAX_SLABS);
  localparam logic [SLAB_W-1:0]  INIT_SLABS =
    SLAB_W'((INITIAL_SLABS < MAX_SLABS) ? INITIAL_SLABS : MAX_SLABS);
  localparam logic [SPP_W-1:0]   SPP_MAX =
    SPP_W'((MAX_SLOTS_PER_SLAB < 128) ? MAX_SLOTS_PER_SLAB : 128);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_STATS = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_DOUBLE    = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

endpackage

### design/slab_free_list_allocator_top.sv
// Slab free-list allocator: LIFO free list threaded through a link RAM.
// Free, stats, spare and exhausted allocate: next-cycle result, busy stays low.
// Allocate from a nonempty list: busy in S_POP, result registered from S_POP.
// Allocate adding a slab: busy in S_THREAD, S_AREAD, S_POP; one link write per slot.
// Reset and any slab size write run an init pass threading INITIAL_SLABS slabs
// (slab size 128 after reset) with busy high; the link RAM itself is never cleared.
module slab_free_list_allocator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_cmd,
  input  logic [slfl_pkg::HANDLE_W-1:0]     in_slot_handle,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [slfl_pkg::SPP_W-1:0]        cfg_slab_size,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [slfl_pkg::HANDLE_W-1:0]     out_granted_handle,
  output logic [slfl_pkg::COUNT_W-1:0]      out_in_use_count,
  output logic [slfl_pkg::COUNT_W-1:0]      out_capacity_count,
  output logic [slfl_pkg::COUNT_W-1:0]      out_peak_in_use,
  output logic [slfl_pkg::SLAB_W-1:0]       out_slab_count,
  output logic [slfl_pkg::TOTAL_W-1:0]      out_alloc_total,
  output logic [slfl_pkg::TOTAL_W-1:0]      out_free_total
);
  import slfl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_THREAD, S_AREAD, S_POP} state_t;

  state_t               state_r, state_nxt;
  logic [SPP_W-1:0]     spp_r, spp_nxt;
  logic [HEAD_W-1:0]    head_r, head_nxt;
  logic [SLAB_W-1:0]    slabs_r, slabs_nxt;
  logic [COUNT_W-1:0]   cap_r, cap_nxt;
  logic [COUNT_W-1:0]   in_use_r, in_use_nxt;
  logic [COUNT_W-1:0]   peak_r, peak_nxt;
  logic [TOTAL_W-1:0]   allocs_r, allocs_nxt;
  logic [TOTAL_W-1:0]   frees_r, frees_nxt;
  logic [HANDLE_W-1:0]  thr_slot_r, thr_slot_nxt;
  logic [SPP_W-1:0]     thr_cnt_r, thr_cnt_nxt;
  logic [SLAB_W-1:0]    init_left_r, init_left_nxt;
  logic                 thr_alloc_r, thr_alloc_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [HANDLE_W-1:0]  out_granted_r;
  logic [COUNT_W-1:0]   out_in_use_r, out_cap_r, out_peak_r;
  logic [SLAB_W-1:0]    out_slabs_r;
  logic [TOTAL_W-1:0]   out_allocs_r, out_frees_r;

  logic                 emit;
  logic [1:0]           emit_status;
  logic [HANDLE_W-1:0]  emit_granted;
  logic [SPP_W-1:0]     cfg_spp;
  logic                 cfg_fire;
  logic                 item_fire;

  logic                 ram_we;
  logic [HANDLE_W-1:0]  ram_waddr;
  logic [HEAD_W-1:0]    ram_wdata;
  logic [HEAD_W-1:0]    ram_rdata;

  slfl_ram #(.WIDTH(HEAD_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r[HANDLE_W-1:0]),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign item_fire = start && !busy;

  always_comb begin
    cfg_spp = cfg_slab_size;
    if (cfg_spp == '0) begin
      cfg_spp = SPP_W'(1);
    end else if (cfg_spp > SPP_MAX) begin
      cfg_spp = SPP_MAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    spp_nxt       = spp_r;
    head_nxt      = head_r;
    slabs_nxt     = slabs_r;
    cap_nxt       = cap_r;
    in_use_nxt    = in_use_r;
    peak_nxt      = peak_r;
    allocs_nxt    = allocs_r;
    frees_nxt     = frees_r;
    thr_slot_nxt  = thr_slot_r;
    thr_cnt_nxt   = thr_cnt_r;
    init_left_nxt = init_left_r;
    thr_alloc_nxt = thr_alloc_r;
    emit          = 1'b0;
    emit_status   = ST_OK;
    emit_granted  = '0;
    ram_we        = 1'b0;
    ram_waddr     = thr_slot_r;
    ram_wdata     = head_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_fire) begin
          // restart the pool with the new slab size
          spp_nxt       = cfg_spp;
          head_nxt      = LIST_EMPTY;
          slabs_nxt     = '0;
          cap_nxt       = '0;
          in_use_nxt    = '0;
          peak_nxt      = '0;
          allocs_nxt    = '0;
          frees_nxt     = '0;
          thr_slot_nxt  = HANDLE_W'(cfg_spp - SPP_W'(1));
          thr_cnt_nxt   = cfg_spp;
          init_left_nxt = INIT_SLABS;
          thr_alloc_nxt = 1'b0;
          state_nxt     = (INIT_SLABS != '0) ? S_THREAD : S_IDLE;
        end else if (item_fire) begin
          case (in_cmd)
            CMD_ALLOC: begin
              if (head_r != LIST_EMPTY) begin
                // link RAM read of the head issues at this edge
                state_nxt = S_POP;
              end else if (slabs_r < SLAB_LIMIT) begin
                thr_slot_nxt  = HANDLE_W'(cap_r + COUNT_W'(spp_r) - COUNT_W'(1));
                thr_cnt_nxt   = spp_r;
                thr_alloc_nxt = 1'b1;
                state_nxt     = S_THREAD;
              end else begin
                emit        = 1'b1;
                emit_status = ST_EXHAUSTED;
              end
            end
            CMD_FREE: begin
              emit = 1'b1;
              if ({1'b0, in_slot_handle} < cap_r) begin
                ram_we    = 1'b1;
                ram_waddr = in_slot_handle;
                ram_wdata = head_r;
                head_nxt  = {1'b0, in_slot_handle};
                frees_nxt = frees_r + TOTAL_W'(1);
                if (in_use_r != '0) begin
                  in_use_nxt = in_use_r - COUNT_W'(1);
                end else begin
                  emit_status = ST_DOUBLE;
                end
              end else begin
                emit_status = ST_BAD;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_THREAD: begin
        // thread one slot per cycle, highest slot first, so slot 0 ends at the head
        ram_we       = 1'b1;
        ram_waddr    = thr_slot_r;
        ram_wdata    = head_r;
        head_nxt     = {1'b0, thr_slot_r};
        thr_slot_nxt = thr_slot_r - HANDLE_W'(1);
        thr_cnt_nxt  = thr_cnt_r - SPP_W'(1);
        if (thr_cnt_r == SPP_W'(1)) begin
          slabs_nxt = slabs_r + SLAB_W'(1);
          cap_nxt   = cap_r + COUNT_W'(spp_r);
          if (thr_alloc_r) begin
            state_nxt = S_AREAD;
          end else begin
            init_left_nxt = init_left_r - SLAB_W'(1);
            if ((init_left_r > SLAB_W'(1)) && (slabs_nxt < SLAB_LIMIT)) begin
              thr_slot_nxt = HANDLE_W'(cap_r + COUNT_W'({spp_r, 1'b0}) - COUNT_W'(1));
              thr_cnt_nxt  = spp_r;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_AREAD: begin
        // head now settled in the RAM; read its link
        state_nxt = S_POP;
      end
      S_POP: begin
        emit         = 1'b1;
        emit_granted = head_r[HANDLE_W-1:0];
        head_nxt     = ram_rdata;
        allocs_nxt   = allocs_r + TOTAL_W'(1);
        if (in_use_r != COUNT_MAX) begin
          in_use_nxt = in_use_r + COUNT_W'(1);
        end
        if (in_use_nxt > peak_r) begin
          peak_nxt = in_use_nxt;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= (INIT_SLABS != '0) ? S_THREAD : S_IDLE;
      spp_r       <= SPP_MAX;
      head_r      <= LIST_EMPTY;
      slabs_r     <= '0;
      cap_r       <= '0;
      in_use_r    <= '0;
      peak_r      <= '0;
      allocs_r    <= '0;
      frees_r     <= '0;
      thr_slot_r  <= HANDLE_W'(SPP_MAX - SPP_W'(1));
      thr_cnt_r   <= SPP_MAX;
      init_left_r <= INIT_SLABS;
      thr_alloc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spp_r       <= spp_nxt;
      head_r      <= head_nxt;
      slabs_r     <= slabs_nxt;
      cap_r       <= cap_nxt;
      in_use_r    <= in_use_nxt;
      peak_r      <= peak_nxt;
      allocs_r    <= allocs_nxt;
      frees_r     <= frees_nxt;
      thr_slot_r  <= thr_slot_nxt;
      thr_cnt_r   <= thr_cnt_nxt;
      init_left_r <= init_left_nxt;
      thr_alloc_r <= thr_alloc_nxt;
      out_valid_r <= emit;
    end
    if (emit) begin
      out_status_r  <= emit_status;
      out_granted_r <= emit_granted;
      out_in_use_r  <= in_use_nxt;
      out_cap_r     <= cap_nxt;
      out_peak_r    <= peak_nxt;
      out_slabs_r   <= slabs_nxt;
      out_allocs_r  <= allocs_nxt;
      out_frees_r   <= frees_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_handle = out_granted_r;
  assign out_in_use_count   = out_in_use_r;
  assign out_capacity_count = out_cap_r;
  assign out_peak_in_use    = out_peak_r;
  assign out_slab_count     = out_slabs_r;
  assign out_alloc_total    = out_allocs_r;
  assign out_free_total     = out_frees_r;

endmodule

### design/slfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slfl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/slfl_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "slab_free_list_allocator_top_assert.svh"

module slfl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        in_cmd,
  input logic                              out_valid,
  input logic [1:0]                        out_status,
  input logic [slfl_pkg::HANDLE_W-1:0]     out_granted_handle,
  input logic [slfl_pkg::COUNT_W-1:0]      out_in_use_count,
  input logic [slfl_pkg::COUNT_W-1:0]      out_capacity_count,
  input logic [slfl_pkg::COUNT_W-1:0]      out_peak_in_use,
  input logic [slfl_pkg::SLAB_W-1:0]       out_slab_count
);
  import slfl_pkg::*;

  // peak tracks the running maximum of in_use
  `SLFL_ASSERT_NOW(a_peak_bound, out_valid, out_in_use_count <= out_peak_in_use,
    "in_use above peak")

  // exhaustion only at the slab limit, with no handle
  `SLFL_ASSERT_NOW(a_exhausted, out_valid && (out_status == ST_EXHAUSTED),
    (out_granted_handle == '0) && (out_slab_count == SLAB_LIMIT),
    "exhausted beat below slab limit or with a handle")

  // granted handles stay inside the pool
  `SLFL_ASSERT_NOW(a_handle_range, out_valid,
    (out_granted_handle == '0) || ({1'b0, out_granted_handle} < out_capacity_count),
    "granted handle beyond capacity")

  // non-allocate commands answer in the next cycle
  `SLFL_ASSERT_NEXT(a_quick_cmd, start && !busy && (in_cmd != CMD_ALLOC), out_valid,
    "free or stats beat missing")

endmodule

bind slab_free_list_allocator_top slfl_checker u_slfl_checker (.*);

### tb/slab_free_list_allocator_checker.sv
// Checker for the slab free-list allocator: predicts every result and compares it.
module slab_free_list_allocator_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_cmd,
  input  logic [slfl_pkg::HANDLE_W-1:0] in_slot_handle,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [slfl_pkg::SPP_W-1:0]    cfg_slab_size,
  input  logic                          out_valid,
  input  logic [1:0]                    out_status,
  input  logic [slfl_pkg::HANDLE_W-1:0] out_granted_handle,
  input  logic [slfl_pkg::COUNT_W-1:0]  out_in_use_count,
  input  logic [slfl_pkg::COUNT_W-1:0]  out_capacity_count,
  input  logic [slfl_pkg::COUNT_W-1:0]  out_peak_in_use,
  input  logic [slfl_pkg::SLAB_W-1:0]   out_slab_count,
  input  logic [slfl_pkg::TOTAL_W-1:0]  out_alloc_total,
  input  logic [slfl_pkg::TOTAL_W-1:0]  out_free_total,
  output int                            mismatch_count,
  output int                            awaited_count
);
  import slfl_pkg::*;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] granted;
    logic [COUNT_W-1:0]  in_use;
    logic [COUNT_W-1:0]  capacity;
    logic [COUNT_W-1:0]  peak;
    logic [SLAB_W-1:0]   slabs;
    logic [TOTAL_W-1:0]  allocs;
    logic [TOTAL_W-1:0]  frees;
  } pool_report_t;

  pool_report_t expected_reports[$];

  logic [HEAD_W-1:0]  link_mem [LINK_DEPTH];
  logic [HEAD_W-1:0]  free_head;
  logic [SPP_W-1:0]   slab_size;
  logic [SLAB_W-1:0]  slab_total;
  logic [COUNT_W-1:0] live_slots;
  logic [COUNT_W-1:0] live_peak;
  logic [TOTAL_W-1:0] grant_tally;
  logic [TOTAL_W-1:0] release_tally;

  int mismatches = 0;
  int awaited    = 0;

  assign mismatch_count = mismatches;
  assign awaited_count  = awaited;

  initial begin
    for (int k = 0; k < LINK_DEPTH; k++) link_mem[k] = '0;
  end

  function automatic int pool_capacity();
    return int'(slab_total) * int'(slab_size);
  endfunction

  // Thread a new slab so that its slot 0 ends up at the head of the list.
  task automatic grow_pool(output bit grown);
    int base;
    if (slab_total >= SLAB_LIMIT) begin
      grown = 1'b0;
    end else begin
      base = pool_capacity();
      for (int i = int'(slab_size); i > 0; i--) begin
        if (base + i - 1 < LINK_DEPTH) link_mem[base + i - 1] = free_head;
        free_head = HEAD_W'(base + i - 1);
      end
      slab_total = slab_total + SLAB_W'(1);
      grown = 1'b1;
    end
  endtask

  task automatic reinit_pool();
    bit ok;
    free_head     = LIST_EMPTY;
    slab_total    = '0;
    live_slots    = '0;
    live_peak     = '0;
    grant_tally   = '0;
    release_tally = '0;
    for (int k = 0; k < int'(INIT_SLABS); k++) begin
      grow_pool(ok);
      if (!ok) break;
    end
  endtask

  task automatic predict_command(input logic [1:0] cmd, input logic [HANDLE_W-1:0] handle);
    pool_report_t r;
    bit have;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_ALLOC: begin
        have = (free_head != LIST_EMPTY);
        if (!have) grow_pool(have);
        if (!have) begin
          r.status = ST_EXHAUSTED;
        end else begin
          r.granted = HANDLE_W'(free_head);
          free_head = (free_head < LINK_DEPTH) ? link_mem[free_head[HANDLE_W-1:0]]
                                               : LIST_EMPTY;
          if (live_slots != COUNT_MAX) live_slots = live_slots + COUNT_W'(1);
          grant_tally = grant_tally + TOTAL_W'(1);
          if (live_slots > live_peak) live_peak = live_slots;
        end
      end
      CMD_FREE: begin
        if (int'(handle) >= pool_capacity()) begin
          r.status = ST_BAD;
        end else begin
          link_mem[handle] = free_head;
          free_head = HEAD_W'(handle);
          // A free with nothing in use still pushes, but the count holds at zero.
          if (live_slots != '0) live_slots = live_slots - COUNT_W'(1);
          else r.status = ST_DOUBLE;
          release_tally = release_tally + TOTAL_W'(1);
        end
      end
      default: ;
    endcase
    r.in_use   = live_slots;
    r.capacity = COUNT_W'(pool_capacity());
    r.peak     = live_peak;
    r.slabs    = slab_total;
    r.allocs   = grant_tally;
    r.frees    = release_tally;
    expected_reports.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    pool_report_t want;
    logic [SPP_W-1:0] size_in;
    if (!rst_n) begin
      slab_size = SPP_MAX;
      reinit_pool();
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_in = cfg_slab_size;
        if (size_in == '0) size_in = SPP_W'(1);
        if (size_in > SPP_MAX) size_in = SPP_MAX;
        slab_size = size_in;
        reinit_pool();
      end
      // Push before popping so a same-edge result would still find its beat.
      if (start && !busy) predict_command(in_cmd, in_slot_handle);
      if (out_valid) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing awaited, status", 32'(out_status), 0);
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 32'(out_status), 32'(want.status));
          check_field("granted_handle", 32'(out_granted_handle), 32'(want.granted));
          check_field("in_use_count", 32'(out_in_use_count), 32'(want.in_use));
          check_field("capacity_count", 32'(out_capacity_count), 32'(want.capacity));
          check_field("peak_in_use", 32'(out_peak_in_use), 32'(want.peak));
          check_field("slab_count", 32'(out_slab_count), 32'(want.slabs));
          check_field("alloc_total", out_alloc_total, want.allocs);
          check_field("free_total", out_free_total, want.frees);
        end
      end
    end
    awaited = expected_reports.size();
  end

endmodule

### tb/tb_slab_free_list_allocator_top.sv
// Stimulus and verdict for the slab free-list allocator, with the checker beside it.
module tb_slab_free_list_allocator_top;
  import slfl_pkg::*;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         PHASE_ITEMS = 115;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_cmd;
  logic [HANDLE_W-1:0]  in_slot_handle;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SPP_W-1:0]     cfg_slab_size;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic [HANDLE_W-1:0]  out_granted_handle;
  logic [COUNT_W-1:0]   out_in_use_count;
  logic [COUNT_W-1:0]   out_capacity_count;
  logic [COUNT_W-1:0]   out_peak_in_use;
  logic [SLAB_W-1:0]    out_slab_count;
  logic [TOTAL_W-1:0]   out_alloc_total;
  logic [TOTAL_W-1:0]   out_free_total;

  int mismatch_count;
  int awaited_count;
  int quiet_cycles = 0;
  int slab_slots   = int'(SPP_MAX);

  always #2 clk = ~clk;

  slab_free_list_allocator_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_slot_handle     (in_slot_handle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_slab_size      (cfg_slab_size),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_in_use_count   (out_in_use_count),
    .out_capacity_count (out_capacity_count),
    .out_peak_in_use    (out_peak_in_use),
    .out_slab_count     (out_slab_count),
    .out_alloc_total    (out_alloc_total),
    .out_free_total     (out_free_total)
  );

  slab_free_list_allocator_checker pool_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_slot_handle     (in_slot_handle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_slab_size      (cfg_slab_size),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_in_use_count   (out_in_use_count),
    .out_capacity_count (out_capacity_count),
    .out_peak_in_use    (out_peak_in_use),
    .out_slab_count     (out_slab_count),
    .out_alloc_total    (out_alloc_total),
    .out_free_total     (out_free_total),
    .mismatch_count     (mismatch_count),
    .awaited_count      (awaited_count)
  );

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Hold the command after a gap until the block takes it; return at a falling edge.
  task automatic send_cmd(input logic [1:0] cmd, input logic [HANDLE_W-1:0] handle,
                          input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          = 1'b1;
    in_cmd         = cmd;
    in_slot_handle = handle;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (awaited_count != 0) @(negedge clk);
  endtask

  task automatic set_slab_size(input logic [SPP_W-1:0] value);
    drain_results();
    cfg_slab_size = value;
    cfg_valid     = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  = 1'b0;
    slab_slots = (value == '0) ? 1 : ((value > SPP_MAX) ? int'(SPP_MAX) : int'(value));
  endtask

  initial begin
    logic [SPP_W-1:0] phase_sizes [8];
    int               alloc_pct;
    int               pick;
    int               gap;
    logic [1:0]       cmd;
    logic [HANDLE_W-1:0] handle;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_STATS;
    in_slot_handle = '0;
    cfg_valid      = 1'b0;
    cfg_slab_size  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reset pool: stats, spare code, bad handles, free with nothing in use, an allocate.
    send_cmd(CMD_STATS, '0, 0);
    send_cmd(CMD_SPARE, 11'd5, 0);
    send_cmd(CMD_FREE, 11'd2047, 1);
    send_cmd(CMD_FREE, 11'd128, 0);
    send_cmd(CMD_FREE, 11'd127, 0);
    send_cmd(CMD_ALLOC, '0, 0);

    // Size zero is taken as one slot per slab: grow to the slab limit, then run dry.
    set_slab_size(8'd0);
    repeat (17) send_cmd(CMD_ALLOC, '0, 0);
    send_cmd(CMD_FREE, 11'd15, 0);
    send_cmd(CMD_FREE, 11'd16, 0);

    // A free with nothing in use links slot 0 to itself; allocs then keep popping it.
    set_slab_size(8'd1);
    repeat (2) send_cmd(CMD_FREE, '0, 0);
    repeat (40) send_cmd(CMD_ALLOC, '0, 0);
    repeat (6) send_cmd(CMD_FREE, '0, 0);
    drain_results();

    phase_sizes[0] = 8'd255;
    phase_sizes[1] = 8'd2;
    phase_sizes[2] = 8'd0;
    phase_sizes[3] = 8'd37;
    phase_sizes[4] = 8'd129;
    phase_sizes[5] = 8'd1;
    phase_sizes[6] = SPP_W'($urandom_range(0, 255));
    phase_sizes[7] = 8'd128;

    foreach (phase_sizes[p]) begin
      set_slab_size(phase_sizes[p]);
      alloc_pct = $urandom_range(30, 70);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        pick = $urandom_range(0, 99);
        handle = '0;
        if (pick < alloc_pct) begin
          cmd = CMD_ALLOC;
        end else if (pick < 92) begin
          cmd = CMD_FREE;
          if ($urandom_range(0, 5) == 0) handle = HANDLE_W'($urandom_range(0, 2047));
          else handle = HANDLE_W'($urandom_range(0, slab_slots * 2 - 1));
        end else if (pick < 98) begin
          cmd = CMD_STATS;
          handle = HANDLE_W'($urandom_range(0, 2047));
        end else begin
          cmd = CMD_SPARE;
        end
        // Alternate stretches of back-to-back commands with gappy ones.
        gap = ((n / 20) % 2 == 0) ? 0 : $urandom_range(0, 8);
        send_cmd(cmd, handle, gap);
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
